FILE: sv/wps_pkg.sv
// wps_pkg: shared constants and codes for the window peak snap block.
// Used by window_peak_snap_unit and wps_ram users; depends on nothing.

package wps_pkg;

   // pixel store geometry
   localparam int MAX_COLS   = 512;
   localparam int MAX_ROWS   = 512;
   localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
   localparam int ADDR_BITS  = $clog2(STORE_DEPTH);

   // field widths
   localparam int COORD_BITS = 9;
   localparam int PIX_BITS   = 8;
   localparam int DIM_BITS   = 10;
   localparam int RAD_BITS   = 4;
   // window positions run from -15 to 511+15
   localparam int POS_BITS   = COORD_BITS + 2;

   // configuration port
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_WINDOW_RADIUS = 2'd2;

   localparam logic [DIM_BITS-1:0] IMAGE_WIDTH_RESET   = DIM_BITS'(512);
   localparam logic [DIM_BITS-1:0] IMAGE_HEIGHT_RESET  = DIM_BITS'(512);
   localparam logic [RAD_BITS-1:0] WINDOW_RADIUS_RESET = RAD_BITS'(7);

   // request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_SNAP  = 1'b1;

endpackage

FILE: sv/wps_ram.sv
// wps_ram: generic single-port RAM, one access per cycle, registered read.
// No dependencies; contents are undefined until written.

module wps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/window_peak_snap_unit.sv
// window_peak_snap_unit: pixel store plus window maximum search sequencer.
// Depends on wps_pkg and wps_ram.
//
// Usage:
//  req channel (req_valid / req_stall): command 0 writes pixel_value at
//  (x_coord, y_coord) into the pixel store and gives no result. Command 1
//  starts a snap around the cursor (x_coord, y_coord).
//  A snap walks the (2r+1) x (2r+1) window, x offset outer, y offset inner,
//  one position per cycle through the single store port and one shared
//  compare unit (r = window_radius). req_stall stays high from accept until
//  the result is loaded into the output register.
//  rsp channel (rsp_valid / rsp_stall): one beat per snap with the position
//  and magnitude of the first strictly largest pixel, found clear if none
//  exceeds zero. The result sits in an output register: while rsp_stall is
//  high, writes and a new snap are still accepted; a finished snap then waits
//  for the register to free up.
//  APB port: image_width at 0x0, image_height at 0x4, window_radius at 0x8.
//  Reset (synchronous, active high) restores register defaults and drops
//  any pending beat; the store is not cleared.

module window_peak_snap_unit
   import wps_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [COORD_BITS-1:0]    req_x_coord,
   input  logic [COORD_BITS-1:0]    req_y_coord,
   input  logic [PIX_BITS-1:0]      req_pixel_value,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [COORD_BITS-1:0]    rsp_snap_x,
   output logic [COORD_BITS-1:0]    rsp_snap_y,
   output logic [PIX_BITS-1:0]      rsp_peak_value,
   output logic                     rsp_found,
   // configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   // ---------------- configuration registers ----------------
   logic [DIM_BITS-1:0] width_ff, width_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [RAD_BITS-1:0] radius_ff, radius_in;
   logic                csr_write;
   logic [1:0]          csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      radius_in = radius_ff;
      if (csr_write) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_in  = pwdata[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:  height_in = pwdata[DIM_BITS-1:0];
            REG_WINDOW_RADIUS: radius_in = pwdata[RAD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:   prdata = CSR_DATA_BITS'(width_ff);
         REG_IMAGE_HEIGHT:  prdata = CSR_DATA_BITS'(height_ff);
         REG_WINDOW_RADIUS: prdata = CSR_DATA_BITS'(radius_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         radius_ff <= WINDOW_RADIUS_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         radius_ff <= radius_in;
      end
   end

   // ---------------- sequencer ----------------
   logic [1:0]          state_ff, state_in;
   logic [POS_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic [POS_BITS-1:0] px_end_ff, px_end_in;
   logic [POS_BITS-1:0] py_start_ff, py_start_in, py_end_ff, py_end_in;
   logic [DIM_BITS-1:0] w_ff, w_in, h_ff, h_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [POS_BITS-1:0] px_d_ff, py_d_ff;
   logic [PIX_BITS-1:0] best_ff, best_in;
   logic [COORD_BITS-1:0] bx_ff, bx_in, by_ff, by_in;

   logic                req_accept, wr_accept, snap_accept;
   logic                wr_in_store, in_image, last_pos, out_free, rsp_load;
   logic [POS_BITS-1:0] x_ext, y_ext, r_ext;
   logic [ADDR_BITS-1:0] ram_addr, wr_addr, rd_addr;
   logic [PIX_BITS-1:0] ram_rdata;

   assign req_stall   = (state_ff != S_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign wr_accept   = req_accept && (req_command == CMD_WRITE) && wr_in_store;
   assign snap_accept = req_accept && (req_command == CMD_SNAP);
   assign wr_in_store = (32'(req_x_coord) < MAX_COLS) && (32'(req_y_coord) < MAX_ROWS);

   assign x_ext = POS_BITS'(req_x_coord);
   assign y_ext = POS_BITS'(req_y_coord);
   assign r_ext = POS_BITS'(radius_ff);

   // positions are two's complement; sign bit set means left of or above the image
   assign in_image = !px_ff[POS_BITS-1] && (px_ff < POS_BITS'(w_ff))
                  && !py_ff[POS_BITS-1] && (py_ff < POS_BITS'(h_ff));
   assign last_pos = (px_ff == px_end_ff) && (py_ff == py_end_ff);
   assign out_free = !rsp_valid || !rsp_stall;
   assign rsp_load = (state_ff == S_DONE) && out_free;

   assign wr_addr  = ADDR_BITS'(req_y_coord) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(req_x_coord);
   assign rd_addr  = ADDR_BITS'(py_ff) * ADDR_BITS'(MAX_COLS) + ADDR_BITS'(px_ff);
   assign ram_addr = wr_accept ? wr_addr : rd_addr;

   wps_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (wr_accept),
      .addr  (ram_addr),
      .wdata (req_pixel_value),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      px_end_in   = px_end_ff;
      py_start_in = py_start_ff;
      py_end_in   = py_end_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      rd_valid_in = 1'b0;
      best_in     = best_ff;
      bx_in       = bx_ff;
      by_in       = by_ff;

      // shared compare: one store read lands per cycle
      if (rd_valid_ff && (ram_rdata > best_ff)) begin
         best_in = ram_rdata;
         bx_in   = px_d_ff[COORD_BITS-1:0];
         by_in   = py_d_ff[COORD_BITS-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (snap_accept) begin
               px_in       = x_ext - r_ext;
               py_in       = y_ext - r_ext;
               px_end_in   = x_ext + r_ext;
               py_start_in = y_ext - r_ext;
               py_end_in   = y_ext + r_ext;
               w_in = (32'(width_ff) > MAX_COLS) ? DIM_BITS'(MAX_COLS) : width_ff;
               h_in = (32'(height_ff) > MAX_ROWS) ? DIM_BITS'(MAX_ROWS) : height_ff;
               best_in  = '0;
               bx_in    = '0;
               by_in    = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_valid_in = in_image;
            if (last_pos) begin
               state_in = S_LAST;
            end else if (py_ff == py_end_ff) begin
               px_in = px_ff + POS_BITS'(1);
               py_in = py_start_ff;
            end else begin
               py_in = py_ff + POS_BITS'(1);
            end
         end
         S_LAST: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      px_end_ff   <= px_end_in;
      py_start_ff <= py_start_in;
      py_end_ff   <= py_end_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      px_d_ff     <= px_ff;
      py_d_ff     <= py_ff;
      best_ff     <= best_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
   end

   // ---------------- output register ----------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [PIX_BITS-1:0]   rsp_peak_ff;
   logic                  rsp_found_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_x_ff     <= bx_ff;
         rsp_y_ff     <= by_ff;
         rsp_peak_ff  <= best_ff;
         rsp_found_ff <= (best_ff != '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_snap_x     = rsp_x_ff;
   assign rsp_snap_y     = rsp_y_ff;
   assign rsp_peak_value = rsp_peak_ff;
   assign rsp_found      = rsp_found_ff;

`ifndef SYNTHESIS
   // store writes only happen between snaps
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr_accept |-> (state_ff == S_IDLE))
      else $error("pixel write during a snap scan");

   // a read in flight was issued by the scan
   a_read_from_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == S_SCAN))
      else $error("store read landed outside a scan");

   // found flag tracks the peak magnitude
   a_found_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_found_ff == (rsp_peak_ff != '0)))
      else $error("found flag disagrees with peak");

   // empty window reports the origin
   a_empty_origin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> ((rsp_x_ff == '0) && (rsp_y_ff == '0)))
      else $error("empty window gave a nonzero position");

   // a pending beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("result register loaded while stalled");
`endif

endmodule
